@@ sv/mi3_pkg.sv @@
package mi3_pkg;

    localparam int ELEM_W = 32;
    // A 2x2 minor of 32-bit elements needs 65 bits.
    localparam int COF_W = 2 * ELEM_W + 1;
    // A row element times a cofactor is 97 bits, and three of them summed are 99 bits.
    localparam int DET_W = 3 * ELEM_W + 3;
    // The quotient is resolved to two bits above the 32-bit result range.
    localparam int Q_W = ELEM_W + 2;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef elem_t [8:0] mat_t;
    typedef logic signed [COF_W-1:0] cof_t;
    typedef cof_t [8:0] cof_mat_t;
    typedef logic signed [DET_W-1:0] det_t;

    localparam elem_t SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam elem_t SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    typedef struct packed {
        mat_t     a;
        cof_mat_t cof;
    } cof_res_t;

    typedef struct packed {
        mat_t     a;
        cof_mat_t cof;
        det_t     det;
    } det_res_t;

    typedef struct packed {
        mat_t r;
        logic singular;
        logic overflow;
    } res_t;

endpackage

@@ sv/mi3_in_if.sv @@
interface mi3_in_if;
    logic valid;
    logic ready;
    logic signed [31:0] a_11;
    logic signed [31:0] a_12;
    logic signed [31:0] a_13;
    logic signed [31:0] a_21;
    logic signed [31:0] a_22;
    logic signed [31:0] a_23;
    logic signed [31:0] a_31;
    logic signed [31:0] a_32;
    logic signed [31:0] a_33;

    modport source (
        output valid, a_11, a_12, a_13, a_21, a_22, a_23, a_31, a_32, a_33,
        input  ready
    );
    modport sink (
        input  valid, a_11, a_12, a_13, a_21, a_22, a_23, a_31, a_32, a_33,
        output ready
    );
endinterface

@@ sv/mi3_out_if.sv @@
interface mi3_out_if;
    logic valid;
    logic ready;
    logic signed [31:0] r_11;
    logic signed [31:0] r_12;
    logic signed [31:0] r_13;
    logic signed [31:0] r_21;
    logic signed [31:0] r_22;
    logic signed [31:0] r_23;
    logic signed [31:0] r_31;
    logic signed [31:0] r_32;
    logic signed [31:0] r_33;
    logic singular;
    logic overflow;

    modport source (
        output valid, r_11, r_12, r_13, r_21, r_22, r_23, r_31, r_32, r_33,
        output singular, overflow,
        input  ready
    );
    modport sink (
        input  valid, r_11, r_12, r_13, r_21, r_22, r_23, r_31, r_32, r_33,
        input  singular, overflow,
        output ready
    );
endinterface

@@ sv/matrix3x3_inverse_core.sv @@
// 3x3 matrix inverse by adjugate over determinant, signed fixed point with
// FRAC_BITS fraction bits in 32-bit elements.
// Channel mat carries one matrix per transfer, elements a_11 to a_33 in row
// order. Channel inv carries the inverse r_11 to r_33 with two flags:
// singular is set when the exact determinant is zero, and then the input
// matrix is passed back unchanged; overflow is set when any entry saturated.
// Each transfer on mat yields exactly one transfer on inv, in order.
// From a transfer on mat to its result on inv, a matrix passes two cofactor
// stages, three determinant stages, a sign stage, one stage per quotient bit
// (34), a rounding stage and the output register. One matrix is taken every
// cycle while inv does not stall; the quotient-bit stages of the nine
// dividers set the depth.
// When inv stalls, the output register holds its result and a skid register
// takes the next one; mat.ready then drops and the whole pipeline freezes,
// losing nothing. mat.ready comes from a register.
// Reset empties every stage and both output registers.
module matrix3x3_inverse_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    mi3_in_if.sink      mat,
    mi3_out_if.source   inv
);

    logic               en;
    mi3_pkg::mat_t      in_a;
    logic               cof_valid;
    mi3_pkg::cof_res_t  cof_data;
    logic               det_valid;
    mi3_pkg::det_res_t  det_data;
    logic               div_valid;
    mi3_pkg::res_t      div_data;
    logic               push;
    logic               out_v_reg;
    logic               skid_v_reg;
    mi3_pkg::res_t      out_reg;
    mi3_pkg::res_t      skid_reg;

    // The pipeline advances whenever the skid register is free.
    assign en        = !skid_v_reg;
    assign mat.ready = en;
    assign in_a = {mat.a_33, mat.a_32, mat.a_31, mat.a_23, mat.a_22, mat.a_21,
                   mat.a_13, mat.a_12, mat.a_11};

    mi3_cofactor u_cofactor (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mat.valid),
        .in_a      (in_a),
        .out_valid (cof_valid),
        .out_data  (cof_data)
    );

    mi3_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cof_valid),
        .in_data   (cof_data),
        .out_valid (det_valid),
        .out_data  (det_data)
    );

    mi3_divider #(
        .FRAC_BITS (FRAC_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (det_valid),
        .in_data   (det_data),
        .out_valid (div_valid),
        .out_data  (div_data)
    );

    // A result leaves the pipeline at every enabled edge with a valid last stage.
    assign push = div_valid && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || inv.ready)
        begin
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= push;
            end
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || inv.ready)
        begin
            if (skid_v_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= div_data;
            end
        end
        else if (push)
        begin
            skid_reg <= div_data;
        end
    end

    assign inv.valid    = out_v_reg;
    assign inv.r_11     = out_reg.r[0];
    assign inv.r_12     = out_reg.r[1];
    assign inv.r_13     = out_reg.r[2];
    assign inv.r_21     = out_reg.r[3];
    assign inv.r_22     = out_reg.r[4];
    assign inv.r_23     = out_reg.r[5];
    assign inv.r_31     = out_reg.r[6];
    assign inv.r_32     = out_reg.r[7];
    assign inv.r_33     = out_reg.r[8];
    assign inv.singular = out_reg.singular;
    assign inv.overflow = out_reg.overflow;

endmodule

@@ sv/mi3_cofactor.sv @@
// Two stages: the eighteen element products, then the signed cofactors.
module mi3_cofactor (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  mi3_pkg::mat_t       in_a,
    output logic                out_valid,
    output mi3_pkg::cof_res_t   out_data
);

    typedef logic signed [2*mi3_pkg::ELEM_W-1:0] prod_t;

    logic [1:0]         v_reg;
    prod_t              pp_next [9];
    prod_t              pn_next [9];
    prod_t              pp_reg  [9];
    prod_t              pn_reg  [9];
    mi3_pkg::mat_t      a_reg;
    mi3_pkg::cof_t      cof_next [9];
    mi3_pkg::cof_res_t  out_reg;

    for (genvar i = 0; i < 3; i++)
    begin : g_row
        for (genvar j = 0; j < 3; j++)
        begin : g_col
            localparam int R0 = (i == 0) ? 1 : 0;
            localparam int R1 = (i == 2) ? 1 : 2;
            localparam int C0 = (j == 0) ? 1 : 0;
            localparam int C1 = (j == 2) ? 1 : 2;
            localparam int K  = 3 * i + j;
            mi3_pkg::cof_t diff;

            assign pp_next[K] = $signed(in_a[3*R0+C0]) * $signed(in_a[3*R1+C1]);
            assign pn_next[K] = $signed(in_a[3*R0+C1]) * $signed(in_a[3*R1+C0]);
            assign diff = mi3_pkg::COF_W'(pp_reg[K]) - mi3_pkg::COF_W'(pn_reg[K]);
            // Cofactors at odd positions carry a minus sign.
            assign cof_next[K] = (((i + j) % 2) == 1) ? -diff : diff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 9; k++)
            begin
                pp_reg[k]      <= pp_next[k];
                pn_reg[k]      <= pn_next[k];
                out_reg.cof[k] <= cof_next[k];
            end
            a_reg     <= in_a;
            out_reg.a <= a_reg;
        end
    end

    assign out_valid = v_reg[1];
    assign out_data  = out_reg;

endmodule

@@ sv/mi3_det.sv @@
// Three stages: split products of row one by its cofactors, the three
// terms, and their sum.
module mi3_det (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  mi3_pkg::cof_res_t   in_data,
    output logic                out_valid,
    output mi3_pkg::det_res_t   out_data
);

    localparam int PW = mi3_pkg::ELEM_W + mi3_pkg::ELEM_W + 1;

    typedef logic signed [PW-1:0] part_t;

    logic [2:0]         v_reg;
    part_t              plo_next [3];
    part_t              phi_next [3];
    part_t              plo_reg  [3];
    part_t              phi_reg  [3];
    mi3_pkg::det_t      t_next   [3];
    mi3_pkg::det_t      t_reg    [3];
    mi3_pkg::cof_res_t  d1_reg;
    mi3_pkg::cof_res_t  d2_reg;
    mi3_pkg::det_res_t  out_reg;

    for (genvar k = 0; k < 3; k++)
    begin : g_term
        // The cofactor is cut into a signed upper part and an unsigned lower word.
        assign phi_next[k] = $signed(in_data.a[k])
            * $signed(in_data.cof[k][mi3_pkg::COF_W-1:mi3_pkg::ELEM_W]);
        assign plo_next[k] = $signed(in_data.a[k])
            * $signed({1'b0, in_data.cof[k][mi3_pkg::ELEM_W-1:0]});
        assign t_next[k] = (mi3_pkg::DET_W'(phi_reg[k]) <<< mi3_pkg::ELEM_W)
            + mi3_pkg::DET_W'(plo_reg[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                phi_reg[k] <= phi_next[k];
                plo_reg[k] <= plo_next[k];
                t_reg[k]   <= t_next[k];
            end
            d1_reg      <= in_data;
            d2_reg      <= d1_reg;
            out_reg.a   <= d2_reg.a;
            out_reg.cof <= d2_reg.cof;
            out_reg.det <= t_reg[0] + t_reg[1] + t_reg[2];
        end
    end

    assign out_valid = v_reg[2];
    assign out_data  = out_reg;

endmodule

@@ sv/mi3_divider.sv @@
// Nine restoring dividers in lockstep, one quotient bit per stage, with a
// sign stage in front and a round and saturate stage behind.
module mi3_divider #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  mi3_pkg::det_res_t   in_data,
    output logic                out_valid,
    output mi3_pkg::res_t       out_data
);

    localparam int NW = mi3_pkg::COF_W + 2 * FRAC_BITS;
    localparam int DW = mi3_pkg::DET_W;
    localparam int QW = mi3_pkg::Q_W;
    localparam int NS = QW;
    localparam int CW = ((NW > DW) ? NW : DW) + QW;
    localparam logic [QW:0] LIM_NEG = (QW + 1)'(1) << (mi3_pkg::ELEM_W - 1);
    localparam logic [QW:0] LIM_POS = LIM_NEG - (QW + 1)'(1);

    typedef logic [NW-1:0] num_t;
    typedef logic [DW-1:0] dvs_t;
    typedef logic [QW-1:0] quo_t;

    logic [NS:0]    v_reg;
    logic           vf_reg;
    num_t           rem_next  [NS+1][9];
    num_t           rem_reg   [NS+1][9];
    quo_t           q_next    [NS+1][9];
    quo_t           q_reg     [NS+1][9];
    dvs_t           d_next    [NS+1];
    dvs_t           d_reg     [NS+1];
    logic [8:0]     neg_next  [NS+1];
    logic [8:0]     neg_reg   [NS+1];
    logic           sing_next [NS+1];
    logic           sing_reg  [NS+1];
    mi3_pkg::mat_t  a_next    [NS+1];
    mi3_pkg::mat_t  a_reg     [NS+1];
    mi3_pkg::res_t  res_next;
    mi3_pkg::res_t  out_reg;

    // Sign stage: magnitudes, signs and the singular test.
    assign d_next[0]    = in_data.det[DW-1] ? dvs_t'(-in_data.det) : dvs_t'(in_data.det);
    assign sing_next[0] = (in_data.det == '0);
    assign a_next[0]    = in_data.a;

    for (genvar i = 0; i < 3; i++)
    begin : g_pi
        for (genvar j = 0; j < 3; j++)
        begin : g_pj
            // Entry (i,j) of the adjugate is cofactor (j,i).
            localparam int L = 3 * i + j;
            mi3_pkg::cof_t c;
            logic [mi3_pkg::COF_W-1:0] cmag;

            assign c    = in_data.cof[3*j+i];
            assign cmag = c[mi3_pkg::COF_W-1] ? -c : c;
            assign rem_next[0][L] = NW'(cmag) << (2 * FRAC_BITS);
            assign q_next[0][L]   = '0;
            assign neg_next[0][L] = c[mi3_pkg::COF_W-1] ^ in_data.det[DW-1];
        end
    end

    // Division stages, most significant quotient bit first.
    for (genvar s = 1; s <= NS; s++)
    begin : g_step
        for (genvar l = 0; l < 9; l++)
        begin : g_lane
            logic [CW-1:0] sh;
            logic          ge;

            assign sh = CW'(d_reg[s-1]) << (QW - s);
            assign ge = CW'(rem_reg[s-1][l]) >= sh;
            assign rem_next[s][l] = ge ? rem_reg[s-1][l] - sh[NW-1:0] : rem_reg[s-1][l];
            assign q_next[s][l]   = {q_reg[s-1][l][QW-2:0], ge};
        end
        assign d_next[s]    = d_reg[s-1];
        assign neg_next[s]  = neg_reg[s-1];
        assign sing_next[s] = sing_reg[s-1];
        assign a_next[s]    = a_reg[s-1];
    end

    // Round half away from zero on the magnitude, then saturate; a singular matrix passes through unchanged.
    always_comb
    begin
        logic [CW-1:0] rem_w;
        logic [CW-1:0] dif_w;
        logic          rnd;
        logic [QW:0]   qr;
        logic [QW:0]   lim;
        logic          ov;

        res_next.overflow = 1'b0;
        res_next.singular = sing_reg[NS];
        for (int l = 0; l < 9; l++)
        begin
            rem_w = CW'(rem_reg[NS][l]);
            dif_w = CW'(d_reg[NS]) - rem_w;
            rnd   = rem_w >= dif_w;
            qr    = {1'b0, q_reg[NS][l]} + (QW + 1)'(rnd);
            lim   = neg_reg[NS][l] ? LIM_NEG : LIM_POS;
            ov    = qr > lim;
            res_next.overflow = res_next.overflow | ov;
            if (ov)
            begin
                res_next.r[l] = neg_reg[NS][l] ? mi3_pkg::SAT_MIN : mi3_pkg::SAT_MAX;
            end
            else if (neg_reg[NS][l])
            begin
                res_next.r[l] = '0 - qr[mi3_pkg::ELEM_W-1:0];
            end
            else
            begin
                res_next.r[l] = qr[mi3_pkg::ELEM_W-1:0];
            end
        end
        if (sing_reg[NS])
        begin
            res_next.r        = a_reg[NS];
            res_next.overflow = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vf_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg  <= {v_reg[NS-1:0], in_valid};
            vf_reg <= v_reg[NS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s <= NS; s++)
            begin
                for (int l = 0; l < 9; l++)
                begin
                    rem_reg[s][l] <= rem_next[s][l];
                    q_reg[s][l]   <= q_next[s][l];
                end
                d_reg[s]    <= d_next[s];
                neg_reg[s]  <= neg_next[s];
                sing_reg[s] <= sing_next[s];
                a_reg[s]    <= a_next[s];
            end
            out_reg <= res_next;
        end
    end

    assign out_valid = vf_reg;
    assign out_data  = out_reg;

endmodule

@@ sv/mi3_checker.sv @@
module mi3_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        mat_valid,
    input logic        mat_ready,
    input logic        inv_valid,
    input logic        inv_ready,
    input logic        inv_singular,
    input logic        inv_overflow,
    input logic [31:0] inv_r_11
);

    // A singular result carries the input matrix back, so overflow is never flagged on it.
    a_sing_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv_singular |-> !inv_overflow)
        else $error("overflow flagged on a singular result");

    // Input back-pressure only follows a stall on the output.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !mat_ready |-> $past(inv_valid && !inv_ready))
        else $error("input not ready without an output stall");

    // A stalled result stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && !inv_ready |=> inv_valid && $stable(inv_r_11)
            && $stable(inv_singular) && $stable(inv_overflow))
        else $error("stalled result changed");

    // After a stall clears, input is ready again in the next cycle.
    a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
        !mat_ready && inv_ready |=> mat_ready)
        else $error("input ready did not recover");

endmodule

bind matrix3x3_inverse_core mi3_checker u_mi3_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .mat_valid    (mat.valid),
    .mat_ready    (mat.ready),
    .inv_valid    (inv.valid),
    .inv_ready    (inv.ready),
    .inv_singular (inv.singular),
    .inv_overflow (inv.overflow),
    .inv_r_11     (inv.r_11)
);

@@ dv/mi3_tb_if.sv @@
`timescale 1ns / 100ps

// The testbench drives the design's own interfaces. This package carries
// the expected result item.
package mi3_tb_pkg;

    typedef struct {
        mi3_pkg::elem_t r [9];
        logic           singular;
        logic           overflow;
    } inv_item_t;
endpackage

@@ dv/matrix3x3_inverse_core_tb.sv @@
`timescale 1ns / 100ps

module matrix3x3_inverse_core_tb;

    localparam int FB = 16;
    localparam int LATENCY = 42;
    localparam int STALL_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mi3_in_if  mat ();
    mi3_out_if inv ();

    matrix3x3_inverse_core #(.FRAC_BITS(FB)) uut (
        .clk(clk), .rst_n(rst_n), .mat(mat), .inv(inv)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected inverses, oldest first.
    mi3_tb_pkg::inv_item_t expected_inv[$];
    int error_count = 0;
    // Sender idling and receiver stalling controls.
    int  src_idle_pct = 17;
    int  snk_stall_pct = 17;
    bit  snk_hold = 1'b0;
    int  idle_cycles = 0;

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Rounded, saturated quotient of n * 2^(2*FB) by d, ties away from zero.
    function automatic mi3_pkg::elem_t div_round_sat(input logic signed [255:0] n,
                                                     input logic signed [255:0] d,
                                                     inout logic ovf);
        logic [255:0] nm;
        logic [255:0] dm;
        logic [255:0] q;
        logic [255:0] rem;
        bit neg;
        neg = (n < 0) != (d < 0);
        nm = (n < 0) ? -n : n;
        dm = (d < 0) ? -d : d;
        nm = nm << (2 * FB);
        q = nm / dm;
        rem = nm % dm;
        if (rem >= dm - rem)
            q = q + 1;
        if (!neg && q > 256'h7FFFFFFF)
        begin
            ovf = 1'b1;
            return mi3_pkg::SAT_MAX;
        end
        if (neg && q > 256'h80000000)
        begin
            ovf = 1'b1;
            return mi3_pkg::SAT_MIN;
        end
        return neg ? mi3_pkg::elem_t'(-q[31:0]) : mi3_pkg::elem_t'(q[31:0]);
    endfunction

    // Adjugate over determinant, exactly as the block should compute it.
    function automatic mi3_tb_pkg::inv_item_t predict_inverse(input mi3_pkg::elem_t a [9]);
        logic signed [255:0] e [3][3];
        logic signed [255:0] cof [3][3];
        logic signed [255:0] det;
        mi3_tb_pkg::inv_item_t res;
        logic ovf;
        ovf = 1'b0;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                e[i][j] = a[i * 3 + j];
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                // Minor of (i,j) from the two remaining rows and columns.
                int r0, r1, c0, c1;
                r0 = (i == 0) ? 1 : 0;
                r1 = (i == 2) ? 1 : 2;
                c0 = (j == 0) ? 1 : 0;
                c1 = (j == 2) ? 1 : 2;
                cof[i][j] = e[r0][c0] * e[r1][c1] - e[r0][c1] * e[r1][c0];
                if ((i + j) % 2 == 1)
                    cof[i][j] = -cof[i][j];
            end
        det = e[0][0] * cof[0][0] + e[0][1] * cof[0][1] + e[0][2] * cof[0][2];
        if (det == 0)
        begin
            res.r = a;
            res.singular = 1'b1;
            res.overflow = 1'b0;
            return res;
        end
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                res.r[i * 3 + j] = div_round_sat(cof[j][i], det, ovf);
        res.singular = 1'b0;
        res.overflow = ovf;
        return res;
    endfunction

    // Offers one matrix and waits for its transfer, with random idle gaps.
    // Valid stays high after the transfer so that the next matrix can follow
    // at once; the caller drops it with stop_sending before pausing.
    task automatic send_matrix(input mi3_pkg::elem_t a [9]);
        while ($urandom_range(99) < src_idle_pct)
        begin
            mat.valid <= 1'b0;
            @(posedge clk);
        end
        mat.valid <= 1'b1;
        {mat.a_11, mat.a_12, mat.a_13} <= {a[0], a[1], a[2]};
        {mat.a_21, mat.a_22, mat.a_23} <= {a[3], a[4], a[5]};
        {mat.a_31, mat.a_32, mat.a_33} <= {a[6], a[7], a[8]};
        do
            @(posedge clk);
        while (!mat.ready);
        expected_inv.push_back(predict_inverse(a));
    endtask

    task automatic stop_sending();
        mat.valid <= 1'b0;
    endtask

    function automatic mi3_pkg::elem_t rand_elem();
        case ($urandom_range(5))
            0: return mi3_pkg::elem_t'($urandom);
            1: return mi3_pkg::elem_t'($urandom_range(0, 4) - 2) <<< FB;
            2: return mi3_pkg::elem_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            3: return $urandom_range(1) ? mi3_pkg::SAT_MAX : mi3_pkg::SAT_MIN;
            default: return mi3_pkg::elem_t'(int'($urandom_range(0, 1 << 18))
                                             - (1 << 17)) <<< 4;
        endcase
    endfunction

    task automatic send_random(input int n);
        mi3_pkg::elem_t a [9];
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < 9; i++)
                a[i] = rand_elem();
            // Now and then force a singular matrix by copying a row or a column.
            case ($urandom_range(9))
                0: for (int j = 0; j < 3; j++) a[6 + j] = a[j];
                1: for (int i = 0; i < 3; i++) a[i * 3 + 2] = a[i * 3];
                default: ;
            endcase
            send_matrix(a);
        end
    endtask

    task automatic wait_drained();
        while (expected_inv.size() != 0)
            @(posedge clk);
    endtask

    // Identity, scaled diagonals, extremes, singular cases and quotients that need rounding.
    task automatic test_directed();
        mi3_pkg::elem_t a [9];
        mi3_pkg::elem_t one;
        mi3_pkg::elem_t mx;
        mi3_pkg::elem_t mn;
        one = mi3_pkg::elem_t'(1) <<< FB;
        mx = mi3_pkg::SAT_MAX;
        mn = mi3_pkg::SAT_MIN;
        a = '{one, 0, 0, 0, one, 0, 0, 0, one};
        send_matrix(a);
        a = '{one * 2, 0, 0, 0, -one, 0, 0, 0, one <<< 2};
        send_matrix(a);
        // Tiny diagonal: each diagonal quotient saturates.
        a = '{1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(a);
        a = '{-1, 0, 0, 0, 1, 0, 0, 0, 1};
        send_matrix(a);
        a = '{mx, 0, 0, 0, mx, 0, 0, 0, mx};
        send_matrix(a);
        a = '{mn, 0, 0, 0, mn, 0, 0, 0, mn};
        send_matrix(a);
        a = '{mn, mx, mn, mx, mn, mx, mx, mx, mn};
        send_matrix(a);
        // Zero matrix and matrices with equal rows are singular.
        a = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_matrix(a);
        a = '{mn, -1, mx, 3, 5, 7, mn, -1, mx};
        send_matrix(a);
        a = '{-1, -1, -1, -1, -1, -1, -1, -1, -1};
        send_matrix(a);
        // Quotients that are not exact and must be rounded.
        a = '{3 * one, 0, 0, 0, one, 0, 0, 0, one};
        send_matrix(a);
        a = '{-3 * one, one, 0, 0, 7 * one, 0, one, 0, one};
        send_matrix(a);
        a = '{2, 0, 0, 0, 2 * one, 0, 0, 0, one};
        send_matrix(a);
        a = '{one, 2 * one, 3 * one, 0, one, 4 * one, 5 * one, 6 * one, 0};
        send_matrix(a);
    endtask

    task automatic test_random_traffic();
        send_random(400);
        // A long stretch with no idling on either side.
        src_idle_pct = 0;
        snk_stall_pct = 0;
        send_random(200);
        src_idle_pct = 17;
        snk_stall_pct = 17;
    endtask

    // The receiver holds off while the sender keeps offering, so the
    // pipeline fills and the block must stall its input.
    task automatic test_backpressure();
        snk_hold = 1'b1;
        send_random(120);
        stop_sending();
        wait (snk_hold == 1'b0);
        wait_drained();
        send_random(100);
    endtask

    // Receiver side: random ready, with a long held-off stretch on request.
    initial
    begin
        inv.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (snk_hold)
            begin
                inv.ready <= 1'b0;
                repeat (300) @(posedge clk);
                snk_hold = 1'b0;
            end
            inv.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // Checks each result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && inv.valid && inv.ready)
        begin
            mi3_tb_pkg::inv_item_t got;
            mi3_tb_pkg::inv_item_t exp_item;
            got.r = '{inv.r_11, inv.r_12, inv.r_13, inv.r_21, inv.r_22, inv.r_23,
                      inv.r_31, inv.r_32, inv.r_33};
            got.singular = inv.singular;
            got.overflow = inv.overflow;
            if (expected_inv.size() == 0)
                report_mismatch("result with no matrix outstanding");
            else
            begin
                exp_item = expected_inv.pop_front();
                for (int i = 0; i < 9; i++)
                    if (got.r[i] !== exp_item.r[i])
                        report_mismatch($sformatf("r_%0d%0d got %h expected %h",
                            i / 3 + 1, i % 3 + 1, got.r[i], exp_item.r[i]));
                if (got.singular !== exp_item.singular)
                    report_mismatch($sformatf("singular got %b expected %b",
                        got.singular, exp_item.singular));
                if (got.overflow !== exp_item.overflow)
                    report_mismatch($sformatf("overflow got %b expected %b",
                        got.overflow, exp_item.overflow));
            end
        end
    end

    // Watchdog: counts cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((mat.valid && mat.ready) || (inv.valid && inv.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        mat.valid <= 1'b0;
        {mat.a_11, mat.a_12, mat.a_13, mat.a_21, mat.a_22} <= '0;
        {mat.a_23, mat.a_31, mat.a_32, mat.a_33} <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_traffic();
        // The sender pauses until every outstanding result has returned.
        stop_sending();
        wait_drained();
        test_backpressure();
        stop_sending();
        wait_drained();
        repeat (LATENCY + 10) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule

@@ filelist.f @@
sv/mi3_pkg.sv
sv/mi3_in_if.sv
sv/mi3_out_if.sv
sv/mi3_cofactor.sv
sv/mi3_det.sv
sv/mi3_divider.sv
sv/matrix3x3_inverse_core.sv
sv/mi3_checker.sv
dv/mi3_tb_if.sv
dv/matrix3x3_inverse_core_tb.sv
